### rtl/lir_pkg.sv
// ----------------------------------------------------------------------------
// lir_pkg: shared definitions for the linear interpolation resampler
// Field widths, register indexes, reset values and controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package lir_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_INPUT_SAMPLES_DEF = 4096;
  localparam int SAMPLE_BITS_DEF       = 16;

  // Fixed field widths
  localparam int SAMPLE_W   = 16;  // sample / value port width
  localparam int STEP_W     = 25;  // step register, Q16
  localparam int COUNT_W    = 16;  // output count per frame
  localparam int POS_W      = 40;  // position, Q24.16
  localparam int FRAC_W     = 16;  // fraction bits of a position
  localparam int RESULT_CAP = 64;  // results per item
  localparam int CAP_W      = $clog2(RESULT_CAP + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = STEP_W;

  localparam logic [CFG_IDX_W-1:0] REG_STEP  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = CFG_IDX_W'(1);

  localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(65536);
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(8);

  // Controller -> datapath
  typedef struct packed {
    logic load;         // take a new item
    logic interp_step;  // produce one interpolated output
    logic tail_step;    // produce one clamped output of the last sample
    logic finish;       // flush held result, update frame state
  } lir_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic interp_due;   // an output lies before the current sample
    logic tail_due;     // frame still owes outputs
    logic cap_full;     // result cap reached for this item
    logic hold_vld;     // a result sits in the hold register
    logic slot_free;    // output register can take a result this cycle
    logic is_last;      // current item ends the frame
  } lir_stat_t;

endpackage

### rtl/lir_in_if.sv
// ----------------------------------------------------------------------------
// lir_in_if: input sample channel
// valid/ready handshake carrying one sample and its end-of-frame mark.
// ----------------------------------------------------------------------------
interface lir_in_if;
  logic                          valid;
  logic                          ready;
  logic [lir_pkg::SAMPLE_W-1:0]  sample;
  logic                          last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

### rtl/lir_out_if.sv
// ----------------------------------------------------------------------------
// lir_out_if: result channel
// valid/ready handshake carrying one output sample and its marks.
// ----------------------------------------------------------------------------
interface lir_out_if;
  logic                          valid;
  logic                          ready;
  logic [lir_pkg::SAMPLE_W-1:0]  value;
  logic                          last_result;
  logic                          frame_done;
  logic                          dropped;

  modport source (output valid, output value, output last_result, output frame_done,
                  output dropped, input ready);
  modport sink   (input valid, input value, input last_result, input frame_done,
                  input dropped, output ready);
endinterface

### rtl/lir_ctrl.sv
// ----------------------------------------------------------------------------
// lir_ctrl: sequencing state machine
// Walks one item through the interpolation loop, the end-of-frame tail and
// the final flush, pacing each step on the output register.
// ----------------------------------------------------------------------------
module lir_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lir_pkg::lir_stat_t stat,
  output lir_pkg::lir_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_INTERP = 4'b0010,
    ST_TAIL   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   can_hold;

  // a new result may enter the hold register
  assign can_hold = !stat.hold_vld || stat.slot_free;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_INTERP;
        end
      end
      ST_INTERP: begin
        if (stat.interp_due) begin
          if (stat.cap_full) begin
            // dropped output: no hold write, only count and advance
            cmd.interp_step = 1'b1;
            if (stat.is_last) begin
              state_nxt = ST_FINISH;
            end
          end else if (can_hold) begin
            cmd.interp_step = 1'b1;
          end
        end else begin
          state_nxt = stat.is_last ? ST_TAIL : ST_FINISH;
        end
      end
      ST_TAIL: begin
        if (stat.tail_due) begin
          if (stat.cap_full) begin
            cmd.tail_step = 1'b1;
            state_nxt     = ST_FINISH;
          end else if (can_hold) begin
            cmd.tail_step = 1'b1;
          end
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (can_hold) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/lir_dp.sv
// ----------------------------------------------------------------------------
// lir_dp: resampler datapath
// Configuration registers, frame state, interpolation arithmetic, the
// one-deep hold register and the output register.
// ----------------------------------------------------------------------------
module lir_dp #(
  parameter int MAX_INPUT_SAMPLES = lir_pkg::MAX_INPUT_SAMPLES_DEF,
  parameter int SAMPLE_BITS       = lir_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lir_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lir_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [lir_pkg::SAMPLE_W-1:0]     in_sample,
  input  logic                             in_last,
  input  lir_pkg::lir_cmd_t                cmd,
  output lir_pkg::lir_stat_t               stat,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [lir_pkg::SAMPLE_W-1:0]     out_value,
  output logic                             out_last_result,
  output logic                             out_frame_done,
  output logic                             out_dropped
);

  localparam int SW     = (SAMPLE_BITS < lir_pkg::SAMPLE_W) ? SAMPLE_BITS : lir_pkg::SAMPLE_W;
  localparam int SEEN_W = $clog2(MAX_INPUT_SAMPLES);
  localparam int FW     = lir_pkg::FRAC_W;
  localparam int PW     = lir_pkg::POS_W;
  localparam int PROD_W = SW + FW + 1;
  localparam int CW     = lir_pkg::CAP_W;

  // configuration
  logic [lir_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [lir_pkg::COUNT_W-1:0] ocount_r, ocount_nxt;

  // frame state
  logic [SW-1:0]               prev_r, prev_nxt;
  logic [SEEN_W-1:0]           seen_r, seen_nxt;
  logic [lir_pkg::COUNT_W-1:0] done_r, done_nxt;
  logic [PW-1:0]               pos_r, pos_nxt;

  // current item
  logic [SW-1:0]               cur_r;
  logic                        last_r;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic                        lost_r, lost_nxt;

  // hold and output registers
  logic [SW-1:0]               hold_val_r;
  logic                        hold_vld_r, hold_vld_nxt;
  logic                        out_vld_r, out_vld_nxt;
  logic [lir_pkg::SAMPLE_W-1:0] out_val_r;
  logic                        out_lr_r, out_fd_r, out_dr_r;

  // arithmetic
  logic [SEEN_W:0]             seen_inc;
  logic                        load_last;
  logic [PW-1:0]               limit, base, diff;
  logic [FW-1:0]               frac;
  logic [FW:0]                 wfrac;
  logic [PROD_W-1:0]           prod;
  logic [SW-1:0]               interp_val;
  logic [PW:0]                 pos_sum;
  logic [PW-1:0]               pos_adv;
  logic                        cap_full, slot_free, wr_hold, push, push_final;
  logic [SW-1:0]               step_val;

  assign seen_inc  = {1'b0, seen_r} + (SEEN_W+1)'(1);
  assign load_last = in_last || (seen_inc >= (SEEN_W+1)'(MAX_INPUT_SAMPLES));

  assign limit = PW'({seen_r, {FW{1'b0}}});
  assign base  = PW'({SEEN_W'(seen_r - SEEN_W'(1)), {FW{1'b0}}});
  assign diff  = pos_r - base;

  always_comb begin
    if (pos_r < base) begin
      frac = '0;
    end else if (diff > PW'({FW{1'b1}})) begin
      frac = '1;
    end else begin
      frac = diff[FW-1:0];
    end
  end

  assign wfrac      = (FW+1)'(1 << FW) - {1'b0, frac};
  assign prod       = PROD_W'(prev_r) * PROD_W'(wfrac) + PROD_W'(cur_r) * PROD_W'(frac);
  assign interp_val = prod[SW+FW-1:FW];

  assign pos_sum = {1'b0, pos_r} + (PW+1)'(step_r);
  assign pos_adv = pos_sum[PW] ? '1 : pos_sum[PW-1:0];

  assign cap_full   = (cnt_r == CW'(lir_pkg::RESULT_CAP));
  assign slot_free  = !out_vld_r || out_ready;
  assign wr_hold    = (cmd.interp_step || cmd.tail_step) && !cap_full;
  assign push_final = cmd.finish && hold_vld_r;
  assign push       = (wr_hold && hold_vld_r) || push_final;
  assign step_val   = cmd.interp_step ? interp_val : cur_r;

  always_comb begin
    stat.interp_due = (seen_r != '0) && (done_r < ocount_r) && (pos_r < limit);
    stat.tail_due   = (done_r < ocount_r);
    stat.cap_full   = cap_full;
    stat.hold_vld   = hold_vld_r;
    stat.slot_free  = slot_free;
    stat.is_last    = last_r;
  end

  always_comb begin
    step_nxt     = step_r;
    ocount_nxt   = ocount_r;
    prev_nxt     = prev_r;
    seen_nxt     = seen_r;
    done_nxt     = done_r;
    pos_nxt      = pos_r;
    cnt_nxt      = cnt_r;
    lost_nxt     = lost_r;
    hold_vld_nxt = hold_vld_r;
    out_vld_nxt  = out_ready ? 1'b0 : out_vld_r;

    if (cfg_we && cfg_index == lir_pkg::REG_STEP) begin
      step_nxt = cfg_wdata[lir_pkg::STEP_W-1:0];
    end
    if (cfg_we && cfg_index == lir_pkg::REG_COUNT) begin
      ocount_nxt = cfg_wdata[lir_pkg::COUNT_W-1:0];
    end

    if (cmd.load) begin
      cnt_nxt  = '0;
      lost_nxt = 1'b0;
    end
    if (cmd.interp_step) begin
      done_nxt = done_r + lir_pkg::COUNT_W'(1);
      pos_nxt  = pos_adv;
    end
    if (cmd.tail_step) begin
      done_nxt = done_r + lir_pkg::COUNT_W'(1);
    end
    if ((cmd.interp_step || cmd.tail_step) && cap_full) begin
      lost_nxt = 1'b1;
    end
    if (wr_hold) begin
      cnt_nxt      = cnt_r + CW'(1);
      hold_vld_nxt = 1'b1;
    end
    if (cmd.finish) begin
      hold_vld_nxt = 1'b0;
      if (last_r) begin
        prev_nxt = '0;
        seen_nxt = '0;
        done_nxt = '0;
        pos_nxt  = '0;
      end else begin
        prev_nxt = cur_r;
        seen_nxt = seen_inc[SEEN_W-1:0];
      end
    end
    if (push) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= lir_pkg::STEP_RESET;
      ocount_r   <= lir_pkg::COUNT_RESET;
      prev_r     <= '0;
      seen_r     <= '0;
      done_r     <= '0;
      pos_r      <= '0;
      cnt_r      <= '0;
      lost_r     <= 1'b0;
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      step_r     <= step_nxt;
      ocount_r   <= ocount_nxt;
      prev_r     <= prev_nxt;
      seen_r     <= seen_nxt;
      done_r     <= done_nxt;
      pos_r      <= pos_nxt;
      cnt_r      <= cnt_nxt;
      lost_r     <= lost_nxt;
      hold_vld_r <= hold_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_r  <= in_sample[SW-1:0];
      last_r <= load_last;
    end
    if (wr_hold) begin
      hold_val_r <= step_val;
    end
    if (push) begin
      out_val_r <= lir_pkg::SAMPLE_W'(hold_val_r);
      out_lr_r  <= push_final;
      out_fd_r  <= push_final && last_r;
      out_dr_r  <= push_final && lost_r;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_value       = out_val_r;
  assign out_last_result = out_lr_r;
  assign out_frame_done  = out_fd_r;
  assign out_dropped     = out_dr_r;

endmodule

### rtl/linear_interp_resampler.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler: linear interpolation resampler
// Resamples a frame of unsigned samples with a Q16 step, floor rounding.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   takes one sample per item, last_sample ends the frame. An item
//           is taken only while no earlier item is still in work.
//   out_ch  returns zero or more results per item, up to 64. The last one
//           of an item carries last_result, plus frame_done at frame end
//           and dropped when outputs past the cap were discarded.
//   cfg_*   write-only registers: index 0 step_q16, index 1 out_count.
//           Write only while the block is idle.
// Sequence:
//   A mid-frame item passes load, one interpolation loop step per result,
//   a loop step that sees the loop is over, and the flush. The last sample
//   of a frame also passes through the tail loop before the flush. One
//   multiply-add per loop step sets the rate; a loop step waits while the
//   hold register cannot pass its result on. A result waits in the hold
//   register until the next one enters or the flush. Discarded outputs
//   beyond the cap each take a loop step, except on the last sample, where
//   the rest are skipped after the first.
// Reset: clears frame state and loads step 65536, count 8.
// Stall: a blocked out_ch holds the output register; the loop waits with
//   one more result parked in the hold register, nothing is lost.
// ----------------------------------------------------------------------------
module linear_interp_resampler #(
  parameter int MAX_INPUT_SAMPLES = lir_pkg::MAX_INPUT_SAMPLES_DEF,
  parameter int SAMPLE_BITS       = lir_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lir_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lir_pkg::CFG_DATA_W-1:0] cfg_wdata,
  lir_in_if.sink                         in_ch,
  lir_out_if.source                      out_ch
);

  lir_pkg::lir_cmd_t  cmd;
  lir_pkg::lir_stat_t stat;

  // sequencing
  lir_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic, state and output register
  lir_dp #(
    .MAX_INPUT_SAMPLES (MAX_INPUT_SAMPLES),
    .SAMPLE_BITS       (SAMPLE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_sample       (in_ch.sample),
    .in_last         (in_ch.last_sample),
    .cmd             (cmd),
    .stat            (stat),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_value       (out_ch.value),
    .out_last_result (out_ch.last_result),
    .out_frame_done  (out_ch.frame_done),
    .out_dropped     (out_ch.dropped)
  );

`ifndef SYNTHESIS
  // a result enters the hold register only if the old one can move on
  a_hold_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.interp_step || cmd.tail_step) && !stat.cap_full && stat.hold_vld
      |-> stat.slot_free)
    else $error("hold register overwritten while output blocked");

  a_flush_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!stat.hold_vld || stat.slot_free))
    else $error("flush issued while output blocked");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("second item accepted during work");

  // frame and drop marks ride only on the final result of an item
  a_marks_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.frame_done || out_ch.dropped) |-> out_ch.last_result)
    else $error("frame_done or dropped without last_result");
`endif

endmodule
